@@ hdl/fcd_pkg.sv @@
// Shared types, constants and helpers for the frame change detector.
// No dependencies; imported by frame_change_detector.
`default_nettype none

package fcd_pkg;

  // Frame geometry limits and derived storage sizes
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned BANK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned PIX_W      = $clog2(BANK_DEPTH);
  localparam int unsigned MEM_AW     = PIX_W + 1;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned CNT_W      = $clog2(BANK_DEPTH + 1);
  localparam int unsigned AREA_W     = CNT_W;

  // Register field widths
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned SKIP_W  = 9;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned CFG_DW  = 17;
  localparam int unsigned CFG_IW  = 3;

  // Luminance in thousandths
  localparam int unsigned LUMA_W    = 18;
  localparam int unsigned LUM_R_K   = 299;
  localparam int unsigned LUM_G_K   = 587;
  localparam int unsigned LUM_B_K   = 114;
  localparam int unsigned LUM_SCALE = 1000;

  // Divide by 1000 as multiply by rounded-up reciprocal; exact for 18-bit input
  localparam int unsigned DIV_SHIFT = 28;
  localparam int unsigned DIV_MUL   = ((1 << DIV_SHIFT) + LUM_SCALE - 1) / LUM_SCALE;
  localparam int unsigned DIV_MW    = 19;
  localparam int unsigned QUO_W     = LUMA_W + DIV_MW - DIV_SHIFT;
  localparam int unsigned MAP_MAX   = 255;
  localparam int unsigned MAP_W     = 8;

  // Changed-fraction compare
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned LIM_W      = FRAC_W + AREA_W;

  typedef logic [CFG_IW-1:0] cfg_index_t;

  localparam cfg_index_t REG_FRAME_WIDTH  = 3'd0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 3'd1;
  localparam cfg_index_t REG_SKIP_ROWS    = 3'd2;
  localparam cfg_index_t REG_LUM_THRESH   = 3'd3;
  localparam cfg_index_t REG_FRACTION     = 3'd4;
  localparam cfg_index_t REG_KEEP_REF     = 3'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  // Zero acts as one, large values clamp to the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/frame_change_detector.sv @@
// Frame change detector: each pixel beat gives one result beat. No new pixel
// is taken until the last one has passed the reference read, the difference,
// the reciprocal multiply and the count/decision step, which waits for a free
// output register; a force beat gives no result. Reset returns control to idle
// and config to defaults; the luminance memory is not cleared and holds garbage
// until written. Depends on fcd_pkg; holds both luminance banks in one memory.
`default_nettype none

module frame_change_detector (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         opcode,
  input  wire logic [7:0]                   red,
  input  wire logic [7:0]                   green,
  input  wire logic [7:0]                   blue,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        diff_value,
  output logic                              map_valid,
  output logic                              frame_end,
  output logic                              decision_valid,
  output logic                              changed,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire fcd_pkg::cfg_index_t          cfg_index,
  input  wire logic [fcd_pkg::CFG_DW-1:0]   cfg_data
);
  import fcd_pkg::*;

  // Config registers
  logic [DIM_W-1:0]  frame_width, frame_height;
  logic [SKIP_W-1:0] skip_rows;
  logic [THR_W-1:0]  lum_threshold;
  logic [FRAC_W-1:0] changed_fraction_q16;
  logic              keep_reference;

  // Frame state
  state_t            state, state_next;
  logic              write_bank, reference_valid, force_pending, frame_forced;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [PIX_W-1:0]  pix_addr;
  logic [CNT_W-1:0]  changed_count;

  // Per-beat captures
  logic [LUMA_W-1:0] lum_r;
  logic              map_ok_r, cmp_r, last_r, ref_ok_r, forced_r;
  logic [LUMA_W-1:0] diff_r;
  logic [QUO_W-1:0]  quo_r;

  // Derived limits
  logic [AREA_W-1:0] area;
  logic [LIM_W-1:0]  limit;

  // Memory
  logic [LUMA_W-1:0] mem [2**MEM_AW];
  logic [LUMA_W-1:0] rd_data;

  logic [DIM_W-1:0]  eff_w, eff_h, cand_w, cand_h;
  logic              cfg_accept, pixel_accept, force_accept, load_out;
  logic              first_pix, col_wrap, last_now, forced_now;
  logic [LUMA_W-1:0] lum;
  logic [LUMA_W+DIV_MW-1:0] prod;
  logic [MAP_W-1:0]  quo_sat, mapv;
  logic              hit, decide;
  logic [CNT_W-1:0]  cnt_new;

  assign cfg_ready    = 1'b1;
  assign cfg_accept   = cfg_valid && cfg_ready;
  assign pixel_accept = in_valid && in_ready && (opcode == OP_PIXEL);
  assign force_accept = in_valid && in_ready && (opcode == OP_FORCE);

  assign eff_w = eff_dim(frame_width, DIM_W'(MAX_WIDTH));
  assign eff_h = eff_dim(frame_height, DIM_W'(MAX_HEIGHT));

  // Effective size after a pending write, for restart detection
  always_comb begin
    cand_w = eff_w;
    cand_h = eff_h;
    if (cfg_accept && cfg_index == REG_FRAME_WIDTH) begin
      cand_w = eff_dim(cfg_data[DIM_W-1:0], DIM_W'(MAX_WIDTH));
    end
    if (cfg_accept && cfg_index == REG_FRAME_HEIGHT) begin
      cand_h = eff_dim(cfg_data[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
    end
  end

  // Raster position of the incoming pixel
  assign first_pix  = (column_count == '0) && (row_count == '0);
  assign col_wrap   = (DIM_W'(column_count) + DIM_W'(1)) >= eff_w;
  assign last_now   = col_wrap && ((DIM_W'(row_count) + DIM_W'(1)) >= eff_h);
  assign forced_now = first_pix ? (reference_valid && force_pending) : frame_forced;

  // Luminance in thousandths
  assign lum = LUMA_W'(LUM_R_K) * LUMA_W'(red) + LUMA_W'(LUM_G_K) * LUMA_W'(green)
             + LUMA_W'(LUM_B_K) * LUMA_W'(blue);

  // Divide by 1000 via reciprocal
  assign prod = (LUMA_W+DIV_MW)'(diff_r) * (LUMA_W+DIV_MW)'(DIV_MUL);

  // Map value, pixel count and frame decision
  always_comb begin
    quo_sat = (quo_r > QUO_W'(MAP_MAX)) ? MAP_W'(MAP_MAX) : quo_r[MAP_W-1:0];
    hit     = map_ok_r && cmp_r && (quo_sat > lum_threshold);
    cnt_new = changed_count + CNT_W'(hit);
    if (!(map_ok_r && cmp_r)) begin
      mapv = '0;
    end else if (hit) begin
      mapv = MAP_W'(MAP_MAX);
    end else begin
      mapv = quo_sat;
    end
    decide = forced_r || ((LIM_W'(cnt_new) << FRAC_SHIFT) > limit);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (pixel_accept) state_next = ST_READ;
      ST_READ: state_next = ST_DIV;
      ST_DIV:  state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_OUT:  load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Both banks: write bank at the current address, reference in the other
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      mem[{write_bank, pix_addr}] <= lum;
      rd_data <= mem[{~write_bank, pix_addr}];
    end
  end

  // Fraction limit, refreshed from config every cycle
  always_ff @(posedge clk) begin
    area  <= AREA_W'(eff_w) * AREA_W'(eff_h);
    limit <= LIM_W'(changed_fraction_q16) * LIM_W'(area);
  end

  // Datapath captures
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      lum_r    <= lum;
      map_ok_r <= reference_valid && !forced_now;
      cmp_r    <= DIM_W'(row_count) >= DIM_W'(skip_rows);
      last_r   <= last_now;
      ref_ok_r <= reference_valid;
      forced_r <= forced_now;
    end
    if (state == ST_READ) begin
      diff_r <= (lum_r >= rd_data) ? (lum_r - rd_data) : (rd_data - lum_r);
    end
    if (state == ST_DIV) begin
      quo_r <= prod[LUMA_W+DIV_MW-1:DIV_SHIFT];
    end
    if (load_out) begin
      diff_value     <= mapv;
      map_valid      <= map_ok_r;
      frame_end      <= last_r;
      decision_valid <= last_r && ref_ok_r;
      changed        <= last_r && ref_ok_r && decide;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      out_valid            <= 1'b0;
      write_bank           <= 1'b0;
      reference_valid      <= 1'b0;
      force_pending        <= 1'b0;
      frame_forced         <= 1'b0;
      column_count         <= '0;
      row_count            <= '0;
      pix_addr             <= '0;
      changed_count        <= '0;
      frame_width          <= DIM_W'(320);
      frame_height         <= DIM_W'(240);
      skip_rows            <= '0;
      lum_threshold        <= '0;
      changed_fraction_q16 <= '0;
      keep_reference       <= 1'b1;
    end else begin
      state <= state_next;

      // Output register
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Force beat
      if (force_accept) begin
        force_pending <= 1'b1;
      end

      // Pixel beat: advance raster position
      if (pixel_accept) begin
        if (first_pix && reference_valid && force_pending) begin
          force_pending <= 1'b0;
        end
        frame_forced <= last_now ? 1'b0 : forced_now;
        if (last_now) begin
          column_count <= '0;
          row_count    <= '0;
          pix_addr     <= '0;
        end else if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_count + ROW_W'(1);
          pix_addr     <= pix_addr + PIX_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
          pix_addr     <= pix_addr + PIX_W'(1);
        end
      end

      // Result: count and end-of-frame decision
      if (load_out) begin
        changed_count <= last_r ? '0 : cnt_new;
        if (last_r) begin
          if (ref_ok_r) begin
            if (decide || !keep_reference) write_bank <= ~write_bank;
          end else begin
            reference_valid <= 1'b1;
            write_bank      <= ~write_bank;
          end
        end
      end

      // Config writes
      if (cfg_accept) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width          <= cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_height         <= cfg_data[DIM_W-1:0];
          REG_SKIP_ROWS:    skip_rows            <= cfg_data[SKIP_W-1:0];
          REG_LUM_THRESH:   lum_threshold        <= cfg_data[THR_W-1:0];
          REG_FRACTION:     changed_fraction_q16 <= cfg_data[FRAC_W-1:0];
          REG_KEEP_REF:     keep_reference       <= cfg_data[0];
          default:          ;
        endcase
        // Frame size change starts over with no reference
        if (cand_w != eff_w || cand_h != eff_h) begin
          reference_valid <= 1'b0;
          frame_forced    <= 1'b0;
          changed_count   <= '0;
          column_count    <= '0;
          row_count       <= '0;
          pix_addr        <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire
